>>> hdl/lgb_pkg.sv
// ----------------------------------------------------------------------------
// lgb_pkg: shared types and constants of the legendre basis evaluator
// widths of the stream fields, register indexes, dimension codes, the
// reciprocal table of the recurrence and the rounding/saturation helpers
// ----------------------------------------------------------------------------
`default_nettype none

package lgb_pkg;

    localparam int COORD_W    = 16;  // q2.14 coordinate
    localparam int VAL_W      = 16;  // q2.14 basis value
    localparam int DEG_W      = 3;   // total degree field
    localparam int P_W        = 32;  // 1d polynomial value, saturated to 32 bits
    localparam int DIM_W      = 2;
    localparam int ORDER_W    = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 3;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;
    localparam int RECIP_W     = 18;  // signed, holds 65536
    localparam int RECIP_SHIFT = 16;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_DIMENSION = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_ORDER = 2'd1;

    // dimension codes
    localparam logic [DIM_W-1:0] DIM_X   = 2'd1;
    localparam logic [DIM_W-1:0] DIM_XY  = 2'd2;
    localparam logic [DIM_W-1:0] DIM_XYZ = 2'd3;

    // command from the sequencing control to the merge stage
    typedef struct packed {
        logic               start;
        logic [DIM_W-1:0]   dim;
        logic [ORDER_W-1:0] ord;
    } t_mrg_cmd;

    // round-to-nearest of 65536/n
    function automatic logic signed [RECIP_W-1:0] recip(input logic [2:0] n);
        logic signed [RECIP_W-1:0] r;
        case (n)
            3'd1:    r = 18'sd65536;
            3'd2:    r = 18'sd32768;
            3'd3:    r = 18'sd21845;
            3'd4:    r = 18'sd16384;
            3'd5:    r = 18'sd13107;
            default: r = 18'sd0;
        endcase
        return r;
    endfunction

    // round half up, then arithmetic shift right
    function automatic logic signed [63:0] rnd64(input logic signed [63:0] v,
                                                 input int unsigned s);
        logic signed [63:0] bias;
        bias = 64'sd1 <<< (s - 1);
        return (v + bias) >>> s;
    endfunction

    function automatic logic signed [31:0] sat64_32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat64_16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/lgb_lane.sv
// ----------------------------------------------------------------------------
// lgb_lane: one coordinate lane of the legendre evaluator
// runs the three-term recurrence p0..pmax for one coordinate, one order at a
// time through the multiply, sum, reciprocal and update phases, and holds the results for the merge stage
// ----------------------------------------------------------------------------
`default_nettype none

module lgb_lane #(
    parameter int MAX_ORDER = 5,
    parameter int FRAC_BITS = 14
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [lgb_pkg::COORD_W-1:0]  i_coord,
    output logic                                     o_busy,
    output logic signed [lgb_pkg::P_W-1:0]           o_p [0:MAX_ORDER]
);
    import lgb_pkg::*;

    localparam int ORD_W = (MAX_ORDER < 2) ? 1 : $clog2(MAX_ORDER + 1);
    localparam int N_W   = $clog2(MAX_ORDER + 2);
    localparam int M1_W  = COORD_W + P_W;
    localparam int NUM_W = ((54 - FRAC_BITS) > 36) ? (54 - FRAC_BITS) : 36;
    localparam int MR_W  = NUM_W + RECIP_W;
    localparam logic signed [P_W-1:0] ONE = P_W'(1) << FRAC_BITS;

    localparam logic [1:0] PH_MUL = 2'd0;  // c * p[n-1]
    localparam logic [1:0] PH_SUM = 2'd1;  // scale, round, subtract
    localparam logic [1:0] PH_RCP = 2'd2;  // times 1/n
    localparam logic [1:0] PH_UPD = 2'd3;  // round, saturate, store

    logic                      r_busy;
    logic [1:0]                r_phase;
    logic [N_W-1:0]            r_n;
    logic signed [COORD_W-1:0] r_c;
    logic signed [P_W-1:0]     r_p1;
    logic signed [P_W-1:0]     r_p2;
    logic signed [M1_W-1:0]    r_m1;
    logic signed [NUM_W-1:0]   r_num;
    logic signed [MR_W-1:0]    r_mr;
    logic signed [P_W-1:0]     r_p [0:MAX_ORDER];

    logic [4:0]             w_coef_a;  // 2n-1
    logic [3:0]             w_coef_b;  // n-1
    logic signed [63:0]     w_prod;
    logic signed [63:0]     w_sub;
    logic signed [63:0]     w_num;
    logic signed [P_W-1:0]  w_pn;

    assign w_coef_b = 4'(r_n - 1'b1);
    assign w_coef_a = {w_coef_b, 1'b1};
    assign w_prod   = r_m1 * $signed({1'b0, w_coef_a});
    assign w_sub    = r_p2 * $signed({1'b0, w_coef_b});
    assign w_num    = rnd64(w_prod, FRAC_BITS) - w_sub;
    assign w_pn     = sat64_32(rnd64(64'(r_mr), RECIP_SHIFT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= PH_MUL;
            r_n     <= N_W'(2);
        end else if (i_start) begin
            r_busy  <= (MAX_ORDER >= 2);
            r_phase <= PH_MUL;
            r_n     <= N_W'(2);
        end else if (r_busy) begin
            r_phase <= r_phase + 2'd1;
            if (r_phase == PH_UPD) begin
                if (r_n == N_W'(MAX_ORDER)) begin
                    r_busy <= 1'b0;
                end else begin
                    r_n <= r_n + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_c    <= i_coord;
            r_p1   <= P_W'(i_coord);
            r_p2   <= ONE;
            r_p[0] <= ONE;
            r_p[1] <= P_W'(i_coord);
        end else if (r_busy) begin
            case (r_phase)
                PH_MUL: begin
                    r_m1 <= r_c * r_p1;
                end
                PH_SUM: begin
                    r_num <= NUM_W'(w_num);
                end
                PH_RCP: begin
                    r_mr <= r_num * recip(3'(r_n));
                end
                PH_UPD: begin
                    r_p[r_n[ORD_W-1:0]] <= w_pn;
                    r_p2 <= r_p1;
                    r_p1 <= w_pn;
                end
                default: begin
                    r_m1 <= r_m1;
                end
            endcase
        end
    end

    assign o_busy = r_busy;
    assign o_p    = r_p;

endmodule

`default_nettype wire

>>> hdl/lgb_merge.sv
// ----------------------------------------------------------------------------
// lgb_merge: tensor-product merge of the lane results
// walks the basis in total-degree order and forms px*py*pz through a
// five-stage stall-all pipeline, when not stalled one item per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lgb_merge #(
    parameter int MAX_ORDER = 5,
    parameter int FRAC_BITS = 14
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire lgb_pkg::t_mrg_cmd                   i_cmd,
    input  wire logic signed [lgb_pkg::P_W-1:0]      i_px [0:MAX_ORDER],
    input  wire logic signed [lgb_pkg::P_W-1:0]      i_py [0:MAX_ORDER],
    input  wire logic signed [lgb_pkg::P_W-1:0]      i_pz [0:MAX_ORDER],
    output logic                                     o_busy,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [lgb_pkg::VAL_W-1:0]         o_value,
    output logic [lgb_pkg::DEG_W-1:0]                o_degree,
    output logic                                     o_last
);
    import lgb_pkg::*;

    localparam int ORD_W  = (MAX_ORDER < 2) ? 1 : $clog2(MAX_ORDER + 1);
    localparam int STAGES = 5;

    // index sequencer
    logic              r_act;
    logic [DIM_W-1:0]  r_dim;
    logic [ORD_W-1:0]  r_ord;
    logic [ORD_W-1:0]  r_d;
    logic [ORD_W-1:0]  r_i;
    logic [ORD_W-1:0]  r_j;

    logic              w_en;
    logic              w_inner;
    logic              w_last;
    logic [ORD_W-1:0]  w_k;

    // pipeline
    logic [STAGES-1:0]      r_vld;
    logic [ORD_W-1:0]       r_deg [0:STAGES-1];
    logic                   r_lst [0:STAGES-1];
    logic signed [P_W-1:0]  r_a;
    logic signed [P_W-1:0]  r_b;
    logic signed [P_W-1:0]  r_c1;
    logic signed [P_W-1:0]  r_c2;
    logic signed [P_W-1:0]  r_c3;
    logic signed [63:0]     r_m_ab;
    logic signed [P_W-1:0]  r_ab;
    logic signed [63:0]     r_m_abc;
    logic signed [VAL_W-1:0] r_val;

    assign w_en = !r_vld[STAGES-1] || i_ready;
    assign w_k  = r_d - r_i - r_j;

    always_comb begin
        case (r_dim)
            DIM_XYZ: w_inner = (r_i != '0) || (r_j != '0);
            DIM_XY:  w_inner = (r_i != '0);
            default: w_inner = 1'b0;
        endcase
    end

    assign w_last = !w_inner && (r_d == r_ord);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_vld <= '0;
        end else begin
            if (i_cmd.start) begin
                r_act <= 1'b1;
                r_dim <= i_cmd.dim;
                r_ord <= ORD_W'(i_cmd.ord);
                r_d   <= '0;
                r_i   <= '0;
                r_j   <= '0;
            end else if (r_act && w_en) begin
                if ((r_dim == DIM_XYZ) && (r_j != '0)) begin
                    r_j <= r_j - 1'b1;
                end else if (w_inner) begin
                    // next x exponent, y restarts at the top of its range
                    r_i <= r_i - 1'b1;
                    r_j <= r_d - r_i + 1'b1;
                end else if (!w_last) begin
                    r_d <= r_d + 1'b1;
                    r_i <= r_d + 1'b1;
                    r_j <= '0;
                end else begin
                    r_act <= 1'b0;
                end
            end
            if (w_en) begin
                r_vld <= {r_vld[STAGES-2:0], r_act};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a      <= i_px[r_i];
            r_b      <= i_py[r_j];
            r_c1     <= i_pz[w_k];
            r_deg[0] <= r_d;
            r_lst[0] <= w_last;
            r_m_ab   <= r_a * r_b;
            r_c2     <= r_c1;
            r_ab     <= sat64_32(rnd64(r_m_ab, FRAC_BITS));
            r_c3     <= r_c2;
            r_m_abc  <= r_ab * r_c3;
            r_val    <= sat64_16(rnd64(r_m_abc, FRAC_BITS));
            for (int s = 1; s < STAGES; s++) begin
                r_deg[s] <= r_deg[s-1];
                r_lst[s] <= r_lst[s-1];
            end
        end
    end

    assign o_busy   = r_act;
    assign o_valid  = r_vld[STAGES-1];
    assign o_value  = r_val;
    assign o_degree = DEG_W'(r_deg[STAGES-1]);
    assign o_last   = r_lst[STAGES-1];

endmodule

`default_nettype wire

>>> hdl/legendre_tensor_basis_eval_core.sv
// ----------------------------------------------------------------------------
// legendre_tensor_basis_eval_core: tensor-product legendre basis evaluator
// takes one point, evaluates the 1d legendre polynomials of each coordinate
// in three parallel lanes and emits the basis values in total-degree order
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                     payload
//  --------  ---------  ----------------------------  -----------------------
//  s_axis    in         s_axis_tvalid/s_axis_tready   coord_x, coord_y, coord_z
//  m_axis    out        m_axis_tvalid/m_axis_tready   basis_value, total_degree,
//                                                     last on m_axis_tlast
//  cfg       in         i_cfg_we (no wait)            dimension, max_order
//
//  the lanes run the recurrence one order at a time, then the merge is started
//  and, unless m_axis_tready stalls it, issues one item per cycle for the N
//  basis functions of the configured order (up to 56); s_axis_tready returns
//  once the index sequencer has issued the last item, before that item leaves the pipeline
//  reset: synchronous, active low; dimension and max_order return to 1
//  stalls: m_axis_tready low freezes the output pipeline and index sequencer only
//
`default_nettype none

module legendre_tensor_basis_eval_core #(
    parameter int MAX_ORDER = 5,
    parameter int FRAC_BITS = 14
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration write port
    input  wire logic                                  i_cfg_we,
    input  wire logic [lgb_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  wire logic [lgb_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    // point stream
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [15:0] coord_x, [31:16] coord_y, [47:32] coord_z
    input  wire logic [lgb_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    // basis stream
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [15:0] basis_value, [18:16] total_degree, [23:19] zero
    output logic [lgb_pkg::OUT_TDATA_W-1:0]            m_axis_tdata,
    output logic                                       m_axis_tlast
);
    import lgb_pkg::*;

    localparam int NLANES = 3;

    // top-level sequencing
    localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a point
    localparam logic [1:0] ST_LANE = 2'd1;  // recurrences running
    localparam logic [1:0] ST_EMIT = 2'd2;  // basis indices being issued

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [DIM_W-1:0]    r_dimension;
    logic [ORDER_W-1:0]  r_max_order;

    logic                      w_in_acc;
    logic [NLANES-1:0]         w_lane_busy;
    logic signed [COORD_W-1:0] w_coord [0:NLANES-1];
    logic signed [P_W-1:0]     w_p     [0:NLANES-1][0:MAX_ORDER];
    t_mrg_cmd                  w_cmd;
    logic                      w_mrg_busy;
    logic signed [VAL_W-1:0]   w_value;
    logic [DEG_W-1:0]          w_degree;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    assign w_coord[0] = s_axis_tdata[15:0];
    assign w_coord[1] = s_axis_tdata[31:16];
    assign w_coord[2] = s_axis_tdata[47:32];

    // configuration registers, writes to unused indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dimension <= DIM_X;
            r_max_order <= ORDER_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_DIMENSION: r_dimension <= i_cfg_wdata[DIM_W-1:0];
                REG_MAX_ORDER: r_max_order <= i_cfg_wdata[ORDER_W-1:0];
                default:       r_dimension <= r_dimension;
            endcase
        end
    end

    // merge command: dimension zero acts as x only, order clamps to MAX_ORDER
    always_comb begin
        w_cmd.start = (r_state == ST_LANE) && (w_lane_busy == '0);
        w_cmd.dim   = (r_dimension == '0) ? DIM_X : r_dimension;
        w_cmd.ord   = (r_max_order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER)
                                                           : r_max_order;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_in_acc) begin
                n_state = ST_LANE;
            end
            ST_LANE: if (w_lane_busy == '0) begin
                n_state = ST_EMIT;
            end
            ST_EMIT: if (!w_mrg_busy) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // one recurrence lane per coordinate; unused lanes still run, the merge
    // only reads their order-zero value which is always one
    for (genvar g = 0; g < NLANES; g++) begin : g_lane
        lgb_lane #(
            .MAX_ORDER (MAX_ORDER),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (w_in_acc),
            .i_coord (w_coord[g]),
            .o_busy  (w_lane_busy[g]),
            .o_p     (w_p[g])
        );
    end

    lgb_merge #(
        .MAX_ORDER (MAX_ORDER),
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_px     (w_p[0]),
        .i_py     (w_p[1]),
        .i_pz     (w_p[2]),
        .o_busy   (w_mrg_busy),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_value  (w_value),
        .o_degree (w_degree),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - VAL_W - DEG_W){1'b0}}, w_degree, w_value};

endmodule

`default_nettype wire

>>> hdl/lgb_checker.sv
// ----------------------------------------------------------------------------
// lgb_checker: port-level checks of the legendre basis evaluator
// watches the two streams and checks ordering, holding and reset behavior
// ----------------------------------------------------------------------------
`default_nettype none

module lgb_checker #(
    parameter int MAX_ORDER = 5
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    input  wire logic                                s_axis_tready,
    input  wire logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic [lgb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  wire logic                                m_axis_tlast
);
    import lgb_pkg::*;

    logic             r_first;
    logic [DEG_W-1:0] r_prev_deg;
    logic             w_out_acc;
    logic [DEG_W-1:0] w_deg;

    assign w_out_acc = m_axis_tvalid && m_axis_tready;
    assign w_deg     = m_axis_tdata[VAL_W + DEG_W - 1:VAL_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first    <= 1'b1;
            r_prev_deg <= '0;
        end else if (w_out_acc) begin
            r_first    <= m_axis_tlast;
            r_prev_deg <= w_deg;
        end
    end

    // stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("output item changed while stalled");

    // a point is followed by its recurrence, no second point next cycle
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken again right after a point");

    // degrees start at zero for each point and never fall or skip
    a_deg_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |-> (r_first ? (w_deg == '0)
                               : ((w_deg == r_prev_deg) || (w_deg == r_prev_deg + 1'b1))))
        else $error("total degree out of order");

    a_deg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_deg <= DEG_W'(MAX_ORDER)))
        else $error("total degree above maximum order");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind legendre_tensor_basis_eval_core lgb_checker #(
    .MAX_ORDER (MAX_ORDER)
) u_lgb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> tb/sv/legendre_tensor_basis_eval_core_tb.sv
// ----------------------------------------------------------------------------
// legendre_tensor_basis_eval_core_tb: self-checking bench of the basis core
// points go in on the slave stream, basis values come back on the master
// stream and are checked one by one against typed values or a bit-exact
// fixed-point model of the recurrence; a directed table first, then random phases of settings
// ----------------------------------------------------------------------------
`default_nettype none

module legendre_tensor_basis_eval_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lgb_pkg::*;

    localparam int     LG_ORDER    = 5;
    localparam int     FRAC        = 14;
    localparam int     RECIP_SHIFT = 16;
    localparam longint ONE         = longint'(1) <<< FRAC;
    localparam longint S32_MIN     = -64'sd2147483648;
    localparam longint S32_MAX     = 64'sd2147483647;
    localparam longint RECIP_TAB [0:LG_ORDER] = '{0, 65536, 32768, 21845, 16384, 13107};

    // indexes past the register file, writes there must change nothing
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_B = 2'd3;

    localparam int SETTLE_CYC  = 40;          // output pipeline plus lane latency
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 45;
    localparam int MAX_PRINTS  = 100;

    // first random phases pin the corners of the settings
    localparam logic [1:0] PH_DIM [0:4] = '{2'd3, 2'd1, 2'd2, 2'd3, 2'd0};
    localparam logic [2:0] PH_ORD [0:4] = '{3'd5, 3'd0, 3'd5, 3'd0, 3'd7};

    typedef longint t_poly [0:LG_ORDER];

    typedef struct {
        logic [VAL_W-1:0] value;
        logic [DEG_W-1:0] degree;
        logic             last;
    } t_basis_exp;

    // directed point: settings to run it under, coordinates, and up to two
    // typed results (n_typed zero means the model predicts the results)
    typedef struct packed {
        logic [1:0]  dim;
        logic [2:0]  ord;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [1:0]  n_typed;
        logic [15:0] v0;
        logic [15:0] v1;
        logic        junk_wr;
    } t_point_row;

    localparam int N_ROWS = 20;
    localparam t_point_row POINT_TAB [0:N_ROWS-1] = '{
        // reset settings: dimension 1, order 1 -> P0 = one, P1 = x
        '{2'd1, 3'd1, 16'h2000, 16'h1234, 16'h4321, 2'd2, 16'h4000, 16'h2000, 1'b0},
        '{2'd1, 3'd1, 16'h8000, 16'h7fff, 16'h7fff, 2'd2, 16'h4000, 16'h8000, 1'b0},
        '{2'd1, 3'd1, 16'h7fff, 16'h8000, 16'h8000, 2'd2, 16'h4000, 16'h7fff, 1'b0},
        // dimension zero behaves as dimension 1
        '{2'd0, 3'd1, 16'h1000, 16'hffff, 16'hffff, 2'd2, 16'h4000, 16'h1000, 1'b0},
        // order zero: a single constant basis value
        '{2'd3, 3'd0, 16'h7fff, 16'h8000, 16'h1111, 2'd1, 16'h4000, 16'h0000, 1'b0},
        '{2'd3, 3'd0, 16'h0000, 16'h0000, 16'h0000, 2'd1, 16'h4000, 16'h0000, 1'b0},
        '{2'd1, 3'd5, 16'h4000, 16'h0000, 16'h0000, 2'd0, 16'h0000, 16'h0000, 1'b0},
        '{2'd1, 3'd5, 16'hc000, 16'h0000, 16'h0000, 2'd0, 16'h0000, 16'h0000, 1'b0},
        // order above the maximum is clamped, large inputs saturate
        '{2'd1, 3'd7, 16'h7fff, 16'h0000, 16'h0000, 2'd0, 16'h0000, 16'h0000, 1'b0},
        '{2'd1, 3'd7, 16'h8000, 16'h0000, 16'h0000, 2'd0, 16'h0000, 16'h0000, 1'b0},
        '{2'd2, 3'd5, 16'h8000, 16'h7fff, 16'h0000, 2'd0, 16'h0000, 16'h0000, 1'b0},
        '{2'd2, 3'd5, 16'h4000, 16'hc000, 16'h5555, 2'd0, 16'h0000, 16'h0000, 1'b0},
        // writes past the register file must not disturb the settings
        '{2'd3, 3'd5, 16'h7fff, 16'h7fff, 16'h7fff, 2'd0, 16'h0000, 16'h0000, 1'b1},
        '{2'd3, 3'd5, 16'h8000, 16'h8000, 16'h8000, 2'd0, 16'h0000, 16'h0000, 1'b0},
        '{2'd3, 3'd6, 16'h0000, 16'h0000, 16'h0000, 2'd0, 16'h0000, 16'h0000, 1'b0},
        '{2'd3, 3'd3, 16'h5555, 16'haaaa, 16'h1234, 2'd0, 16'h0000, 16'h0000, 1'b0},
        '{2'd2, 3'd2, 16'hffff, 16'h0001, 16'hffff, 2'd0, 16'h0000, 16'h0000, 1'b0},
        '{2'd1, 3'd4, 16'h0001, 16'hffff, 16'h8000, 2'd0, 16'h0000, 16'h0000, 1'b0},
        '{2'd3, 3'd5, 16'h2aaa, 16'hd555, 16'h0f0f, 2'd0, 16'h0000, 16'h0000, 1'b0},
        '{2'd0, 3'd0, 16'hffff, 16'hffff, 16'hffff, 2'd1, 16'h4000, 16'h0000, 1'b0}
    };

    // dut ports, the inputs all driven from time zero
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [15:0] coord_x, [31:16] coord_y, [47:32] coord_z
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [15:0] basis_value, [18:16] total_degree, [23:19] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    // mirror of the register file as last written
    logic [1:0]  cfg_dim = 2'd1;
    logic [2:0]  cfg_ord = 3'd1;

    t_basis_exp  basis_q [$];   // basis values still to come, oldest first
    int          err_cnt = 0;
    bit          quiet_tx = 1'b0;
    bit          quiet_rx = 1'b0;

    legendre_tensor_basis_eval_core #(
        .MAX_ORDER (LG_ORDER),
        .FRAC_BITS (FRAC)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // hard stop far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // fixed-point model of the evaluator
    // ------------------------------------------------------------------

    // add half an lsb, then floor-shift (round half up)
    function automatic longint round_half_up(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // append one expected basis value at the tail of the queue
    function automatic void queue_basis(input t_basis_exp e);
        basis_q = {basis_q, e};
    endfunction

    // p[0..5] of one coordinate by the three-term recurrence,
    // with the division by n as a multiply by the reciprocal table
    function automatic void legendre_row(input logic signed [15:0] c_raw, output t_poly p);
        longint c;
        longint t;
        longint num;
        int     n;
        c    = c_raw;
        p[0] = ONE;
        p[1] = c;
        for (n = 2; n <= LG_ORDER; n++) begin
            t    = round_half_up(longint'(2 * n - 1) * c * p[n-1], FRAC);
            num  = t - longint'(n - 1) * p[n-2];
            p[n] = clamp(round_half_up(num * RECIP_TAB[n], RECIP_SHIFT), S32_MIN, S32_MAX);
        end
    endfunction

    // queue every basis value the point gives under the current settings
    function automatic void predict_basis(input logic [15:0] x, input logic [15:0] y,
                                          input logic [15:0] z);
        t_poly      px;
        t_poly      py;
        t_poly      pz;
        int         dim;
        int         ord;
        int         d;
        int         i;
        int         j;
        int         i_lo;
        int         j_lo;
        int         n;
        longint     ab;
        t_basis_exp e;
        dim = (cfg_dim == 2'd0) ? 1 : int'(cfg_dim);
        ord = (int'(cfg_ord) > LG_ORDER) ? LG_ORDER : int'(cfg_ord);
        legendre_row(x, px);
        // an unused coordinate contributes a constant one
        for (n = 0; n <= LG_ORDER; n++) begin
            py[n] = ONE;
            pz[n] = ONE;
        end
        if (dim > 1) begin
            legendre_row(y, py);
        end
        if (dim > 2) begin
            legendre_row(z, pz);
        end
        // total degree ascending, x exponent descending, then y descending
        for (d = 0; d <= ord; d++) begin
            i_lo = (dim == 1) ? d : 0;
            for (i = d; i >= i_lo; i--) begin
                j_lo = (dim == 3) ? 0 : d - i;
                for (j = d - i; j >= j_lo; j--) begin
                    ab       = clamp(round_half_up(px[i] * py[j], FRAC), S32_MIN, S32_MAX);
                    e.value  = 16'(clamp(round_half_up(ab * pz[d-i-j], FRAC), -32768, 32767));
                    e.degree = 3'(d);
                    e.last   = (d == ord) && (i == i_lo) && (j == j_lo);
                    queue_basis(e);
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        // keep the log bounded when the core is badly off
        if (err_cnt < MAX_PRINTS) begin
            $display("mismatch @%0t: %s", $realtime, msg);
        end
        err_cnt++;
    endtask

    // one register write; the index is not checked against the map here
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (addr == REG_DIMENSION) begin
            cfg_dim = data[1:0];
        end else if (addr == REG_MAX_ORDER) begin
            cfg_ord = data;
        end
    endtask

    // offer one point after a random gap, return at its accepting edge
    task automatic send_point(input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop offering, let every expected value come back, then let the
    // lanes and output pipeline settle before touching the registers
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (basis_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [1:0] dim, input logic [2:0] ord,
                                  input bit junk);
        wait_drained();
        if (junk) begin
            write_reg(REG_UNUSED_A, 3'($urandom_range(0, 7)));
            write_reg(REG_UNUSED_B, 3'b111);
        end
        write_reg(REG_DIMENSION, {1'b0, dim});
        write_reg(REG_MAX_ORDER, ord);
    endtask

    // half unit-interval points, the rest full-range values with corners mixed in
    function automatic logic [15:0] pick_coord();
        logic [15:0] c;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 6))
                    0:       c = 16'h8000;
                    1:       c = 16'h7fff;
                    2:       c = 16'h4000;
                    3:       c = 16'hc000;
                    4:       c = 16'h0000;
                    5:       c = 16'hffff;
                    default: c = 16'h0001;
                endcase
            end
            1, 2, 3, 4, 5: begin
                c = 16'($signed($urandom_range(0, 32768)) - 16384);
            end
            default: begin
                c = 16'($urandom);
            end
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // basis stream receiver and checker
    // ------------------------------------------------------------------
    initial begin
        int         stall;
        t_basis_exp e;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = quiet_rx ? 0 : $urandom_range(0, 4);
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            if (basis_q.size() == 0) begin
                report_mismatch($sformatf("unexpected item %h last %b",
                                          m_axis_tdata, m_axis_tlast));
            end else begin
                e = basis_q.pop_front();
                if (m_axis_tdata[15:0] !== e.value) begin
                    report_mismatch($sformatf("basis value %h, want %h",
                                              m_axis_tdata[15:0], e.value));
                end
                if (m_axis_tdata[18:16] !== e.degree) begin
                    report_mismatch($sformatf("total degree %0d, want %0d",
                                              m_axis_tdata[18:16], e.degree));
                end
                if (m_axis_tlast !== e.last) begin
                    report_mismatch($sformatf("last %b, want %b", m_axis_tlast, e.last));
                end
                if (m_axis_tdata[23:19] !== 5'd0) begin
                    report_mismatch($sformatf("pad bits %b, want zero", m_axis_tdata[23:19]));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        t_point_row row;
        t_basis_exp e;
        int         r;
        int         k;
        int         ph;
        logic [1:0] dim;
        logic [2:0] ord;

        // reset once at the start, then release it
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; the first rows run on the reset settings
        for (r = 0; r < N_ROWS; r++) begin
            row = POINT_TAB[r];
            if (row.dim != cfg_dim || row.ord != cfg_ord || row.junk_wr) begin
                apply_settings(row.dim, row.ord, row.junk_wr);
            end
            send_point(row.x, row.y, row.z);
            if (row.n_typed == 2'd0) begin
                predict_basis(row.x, row.y, row.z);
            end else begin
                for (k = 0; k < int'(row.n_typed); k++) begin
                    e.value  = (k == 0) ? row.v0 : row.v1;
                    e.degree = 3'(k);
                    e.last   = (k == int'(row.n_typed) - 1);
                    queue_basis(e);
                end
            end
        end

        // random phases, each on its own settings and idling mix
        for (ph = 0; ph < PHASES; ph++) begin
            if (ph < 5) begin
                dim = PH_DIM[ph];
                ord = PH_ORD[ph];
            end else begin
                dim = 2'($urandom_range(0, 3));
                ord = 3'($urandom_range(0, 7));
            end
            apply_settings(dim, ord, $urandom_range(0, 3) == 0);
            // one phase in three without idling on a side
            quiet_tx = ($urandom_range(0, 2) == 0);
            quiet_rx = ($urandom_range(0, 2) == 0);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                row.x = pick_coord();
                row.y = pick_coord();
                row.z = pick_coord();
                send_point(row.x, row.y, row.z);
                predict_basis(row.x, row.y, row.z);
            end
        end

        wait_drained();
        if (err_cnt == 0 && basis_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
